FILE: hdl/kmhd_pkg.sv
// Shared types and constants for the key matrix history debouncer.
`default_nettype none

package kmhd_pkg;

    localparam int HIST_W    = 8;
    localparam int ROW_W     = 16;
    localparam int TOTAL_W   = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 8;

    localparam logic [HIST_W-1:0]  HIST_TOP   = 8'h80;
    localparam logic [HIST_W-1:0]  HIST_FULL  = 8'hFF;
    localparam logic [TOTAL_W-1:0] TOTAL_SAT  = 8'hFF;
    localparam int                 TOTAL_MAX  = 255;

    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_SIXKEY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_NKEY   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NKEY_MODE    = 2'd3;

    typedef struct packed {
        logic [HIST_W-1:0] press_sixkey;
        logic [HIST_W-1:0] press_nkey;
        logic [HIST_W-1:0] release_thr;
        logic              nkey_mode;
    } t_cfg;

    typedef struct packed {
        logic       in_range;
        logic [2:0] row;
        logic [3:0] pos;
        logic [3:0] col;
        logic       press;
    } t_cmd;

    typedef struct packed {
        logic [ROW_W-1:0]   row_bits;
        logic               key_down;
        logic               changed;
        logic [TOTAL_W-1:0] total;
    } t_res;

endpackage

`default_nettype wire

FILE: hdl/kmhd_queue.sv
// Two-entry queue used between the front and back ends and on the result side.
`default_nettype none

module kmhd_queue #(
    parameter int WIDTH = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;
    logic [1:0]       n_cnt;
    logic             push_ok;
    logic             pop_ok;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;

    always_comb begin
        n_cnt = r_cnt;
        if (push_ok && !pop_ok) begin
            n_cnt = r_cnt + 2'd1;
        end else if (pop_ok && !push_ok) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (push_ok) begin
                r_wp <= !r_wp;
            end
            if (pop_ok) begin
                r_rp <= !r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/kmhd_front.sv
// Front end: accepts raw samples, range-checks them and maps scan position to column.
`default_nettype none

module kmhd_front #(
    parameter int ROWS      = 8,
    parameter int POSITIONS = 16
) (
    input  wire logic       i_push,
    input  wire logic       i_q_full,
    input  wire logic [2:0] i_row_index,
    input  wire logic [3:0] i_scan_position,
    input  wire logic       i_pressed,
    output logic            o_q_push,
    output kmhd_pkg::t_cmd  o_cmd
);

    logic in_range;

    assign in_range = (int'(i_row_index) < ROWS) && (int'(i_scan_position) < POSITIONS);

    assign o_q_push = i_push && !i_q_full;

    always_comb begin
        o_cmd.in_range = in_range;
        o_cmd.row      = i_row_index;
        o_cmd.pos      = i_scan_position;
        // odd positions land in the upper half of the row
        o_cmd.col      = {i_scan_position[0], i_scan_position[3:1]};
        o_cmd.press    = i_pressed;
    end

endmodule

`default_nettype wire

FILE: hdl/kmhd_back.sv
// Back end: history store read-modify-write, debounce decision, row state and key count.
`default_nettype none

module kmhd_back #(
    parameter int ROWS      = 8,
    parameter int POSITIONS = 16
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire kmhd_pkg::t_cfg i_cfg,
    input  wire logic           i_cmd_vld,
    input  wire kmhd_pkg::t_cmd i_cmd,
    output logic                o_cmd_pop,
    output logic                o_res_vld,
    output kmhd_pkg::t_res      o_res,
    input  wire logic           i_res_ready
);

    localparam int DEPTH = ROWS * POSITIONS;
    localparam int SW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    logic [kmhd_pkg::HIST_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]            r_vld_bits;
    logic [kmhd_pkg::ROW_W-1:0]  r_rows [ROWS];
    logic [CW-1:0]               r_cnt;
    logic [CW-1:0]               n_cnt;

    logic                        r_b_vld;
    kmhd_pkg::t_cmd              r_b_cmd;
    logic [kmhd_pkg::HIST_W-1:0] r_rd_q;
    logic                        r_rd_ok;
    logic                        r_byp;
    logic [kmhd_pkg::HIST_W-1:0] r_byp_data;

    logic                        ready_b;
    logic                        b_fire;
    logic                        b_wr;
    logic [SW-1:0]               a_slot;
    logic [SW-1:0]               b_slot;
    logic [RW-1:0]               b_row;
    logic [kmhd_pkg::HIST_W-1:0] hist_old;
    logic [kmhd_pkg::HIST_W-1:0] hist_new;
    logic [kmhd_pkg::HIST_W-1:0] thr;
    logic [kmhd_pkg::ROW_W-1:0]  mask;
    logic [kmhd_pkg::ROW_W-1:0]  row_prev;
    logic [kmhd_pkg::ROW_W-1:0]  after;
    logic                        was_down;
    logic                        is_down;

    assign b_fire    = r_b_vld && i_res_ready;
    assign ready_b   = !r_b_vld || i_res_ready;
    assign o_cmd_pop = i_cmd_vld && ready_b;
    assign b_wr      = b_fire && r_b_cmd.in_range;

    assign a_slot = SW'(int'(i_cmd.row) * POSITIONS + int'(i_cmd.pos));
    assign b_slot = SW'(int'(r_b_cmd.row) * POSITIONS + int'(r_b_cmd.pos));
    assign b_row  = RW'(r_b_cmd.row);

    // forwarded write wins over the store, an unwritten entry reads as zero
    assign hist_old = r_byp ? r_byp_data : (r_rd_ok ? r_rd_q : '0);
    assign hist_new = {r_b_cmd.press, hist_old[kmhd_pkg::HIST_W-1:1]};
    assign thr      = i_cfg.nkey_mode ? i_cfg.press_nkey : i_cfg.press_sixkey;
    assign mask     = kmhd_pkg::ROW_W'(1) << r_b_cmd.col;
    assign row_prev = r_rows[b_row];

    always_comb begin
        after = row_prev;
        if (hist_new != '0 && hist_new != kmhd_pkg::HIST_FULL) begin
            if (hist_new >= thr) begin
                after = row_prev | mask;
            end else if (hist_new <= i_cfg.release_thr) begin
                after = row_prev & ~mask;
            end
        end
    end

    assign was_down = (row_prev & mask) != '0;
    assign is_down  = (after & mask) != '0;

    always_comb begin
        n_cnt = r_cnt;
        if (r_b_cmd.in_range) begin
            if (is_down && !was_down) begin
                n_cnt = r_cnt + CW'(1);
            end else if (!is_down && was_down && r_cnt != '0) begin
                n_cnt = r_cnt - CW'(1);
            end
        end
    end

    assign o_res_vld = r_b_vld;

    always_comb begin
        o_res.row_bits = r_b_cmd.in_range ? after : '0;
        o_res.key_down = r_b_cmd.in_range && is_down;
        o_res.changed  = r_b_cmd.in_range && (is_down != was_down);
        o_res.total    = (int'(n_cnt) > kmhd_pkg::TOTAL_MAX) ? kmhd_pkg::TOTAL_SAT
                                                           : kmhd_pkg::TOTAL_W'(n_cnt);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld    <= 1'b0;
            r_vld_bits <= '0;
            r_cnt      <= '0;
            for (int i = 0; i < ROWS; i++) begin
                r_rows[i] <= '0;
            end
        end else begin
            if (ready_b) begin
                r_b_vld <= i_cmd_vld;
            end
            if (b_wr) begin
                r_vld_bits[b_slot] <= 1'b1;
                r_rows[b_row]      <= after;
                r_cnt              <= n_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_b_cmd    <= i_cmd;
            r_byp      <= b_wr && (b_slot == a_slot);
            r_byp_data <= hist_new;
            r_rd_ok    <= i_cmd.in_range && r_vld_bits[a_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop && i_cmd.in_range) begin
            r_rd_q <= r_mem[a_slot];
        end
        if (b_wr) begin
            r_mem[b_slot] <= hist_new;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/key_matrix_history_debouncer.sv
// Top level of the key matrix history debouncer.
//
//   channel   direction  handshake            payload
//   sample    in         push / full          i_row_index, i_scan_position, i_pressed
//   result    out        empty / pop          o_row_bits, o_key_down, o_changed,
//                                             o_keys_down_total
//   config    in         i_cfg_wr_en          i_cfg_index, i_cfg_wdata
//
// One transaction per cycle sustained while the result side keeps popping.
// The history store is read through a register, with same-key
// forwarding so back-to-back samples of one key see the fresh history.
// Reset clears the control state but not the history store; entries carry valid bits.
// Input and result sides each have a two-entry queue; a stalled result side backs up into the input.
`default_nettype none

module key_matrix_history_debouncer #(
    parameter int ROWS      = 8,
    parameter int POSITIONS = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               push,
    output logic                                    full,
    input  wire logic [2:0]                         i_row_index,
    input  wire logic [3:0]                         i_scan_position,
    input  wire logic                               i_pressed,
    output logic                                    empty,
    input  wire logic                               pop,
    output logic [kmhd_pkg::ROW_W-1:0]              o_row_bits,
    output logic                                    o_key_down,
    output logic                                    o_changed,
    output logic [kmhd_pkg::TOTAL_W-1:0]            o_keys_down_total,
    input  wire logic                               i_cfg_wr_en,
    input  wire logic [kmhd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [kmhd_pkg::CFG_DAT_W-1:0]     i_cfg_wdata
);

    kmhd_pkg::t_cfg r_cfg;
    kmhd_pkg::t_cmd front_cmd;
    kmhd_pkg::t_cmd q_cmd;
    kmhd_pkg::t_res back_res;
    kmhd_pkg::t_res out_res;
    logic           q_push;
    logic           q_empty;
    logic           q_pop;
    logic           res_vld;
    logic           res_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.press_sixkey <= 8'd224;
            r_cfg.press_nkey   <= 8'd192;
            r_cfg.release_thr  <= 8'd15;
            r_cfg.nkey_mode    <= 1'b0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                kmhd_pkg::CFG_PRESS_SIXKEY: r_cfg.press_sixkey <= i_cfg_wdata;
                kmhd_pkg::CFG_PRESS_NKEY:   r_cfg.press_nkey   <= i_cfg_wdata;
                kmhd_pkg::CFG_RELEASE:      r_cfg.release_thr  <= i_cfg_wdata;
                kmhd_pkg::CFG_NKEY_MODE:    r_cfg.nkey_mode    <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    kmhd_front #(
        .ROWS      (ROWS),
        .POSITIONS (POSITIONS)
    ) u_front (
        .i_push          (push),
        .i_q_full        (full),
        .i_row_index     (i_row_index),
        .i_scan_position (i_scan_position),
        .i_pressed       (i_pressed),
        .o_q_push        (q_push),
        .o_cmd           (front_cmd)
    );

    kmhd_queue #(
        .WIDTH ($bits(kmhd_pkg::t_cmd))
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (front_cmd),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_data  (q_cmd),
        .o_empty (q_empty)
    );

    kmhd_back #(
        .ROWS      (ROWS),
        .POSITIONS (POSITIONS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_vld   (!q_empty),
        .i_cmd       (q_cmd),
        .o_cmd_pop   (q_pop),
        .o_res_vld   (res_vld),
        .o_res       (back_res),
        .i_res_ready (!res_full)
    );

    kmhd_queue #(
        .WIDTH ($bits(kmhd_pkg::t_res))
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_vld),
        .i_data  (back_res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (out_res),
        .o_empty (empty)
    );

    assign o_row_bits        = out_res.row_bits;
    assign o_key_down        = out_res.key_down;
    assign o_changed         = out_res.changed;
    assign o_keys_down_total = out_res.total;

endmodule

`default_nettype wire

FILE: bench/kmhd_checker.sv
// Checker for the key matrix history debouncer: predicts every result and compares it.
module kmhd_checker
    import kmhd_pkg::*;
#(
    parameter int ROWS      = 8,
    parameter int POSITIONS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic                 i_full,
    input  logic [2:0]           i_row_index,
    input  logic [3:0]           i_scan_position,
    input  logic                 i_pressed,
    input  logic                 i_empty,
    input  logic                 i_pop,
    input  logic [ROW_W-1:0]     i_row_bits,
    input  logic                 i_key_down,
    input  logic                 i_changed,
    input  logic [TOTAL_W-1:0]   i_keys_down_total,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_wdata,
    output int                   o_pending,
    output int                   o_fail_count
);

    t_cfg              cfg;
    logic [HIST_W-1:0] key_hist [ROWS*POSITIONS];
    logic [ROW_W-1:0]  key_rows [ROWS];
    int                keys_down;
    int                fails = 0;
    t_res              expected_reports [$];

    function automatic t_res debounce_sample(input logic [2:0] r, input logic [3:0] p,
                                             input logic k);
        t_res              res;
        int                slot;
        logic [3:0]        col;
        logic [HIST_W-1:0] hist;
        logic [HIST_W-1:0] thr;
        logic [ROW_W-1:0]  was_row;
        logic [ROW_W-1:0]  now_row;
        slot = int'(r) * POSITIONS + int'(p);
        col = p[3:1] + (p[0] ? 4'd8 : 4'd0);
        hist = (key_hist[slot] >> 1) | (k ? HIST_TOP : 8'h00);
        key_hist[slot] = hist;
        was_row = key_rows[r];
        now_row = was_row;
        if (hist != 8'h00 && hist != HIST_FULL) begin
            thr = cfg.nkey_mode ? cfg.press_nkey : cfg.press_sixkey;
            if (hist >= thr) begin
                now_row[col] = 1'b1;
            end else if (hist <= cfg.release_thr) begin
                now_row[col] = 1'b0;
            end
        end
        key_rows[r] = now_row;
        if (now_row[col] && !was_row[col]) begin
            keys_down++;
        end else if (!now_row[col] && was_row[col] && keys_down > 0) begin
            keys_down--;
        end
        res.row_bits = now_row;
        res.key_down = now_row[col];
        res.changed  = now_row[col] ^ was_row[col];
        res.total    = (keys_down > TOTAL_MAX) ? TOTAL_SAT : TOTAL_W'(keys_down);
        return res;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        t_res want;
        if (!i_rst_n) begin
            cfg = '{press_sixkey: 8'd224, press_nkey: 8'd192, release_thr: 8'd15,
                    nkey_mode: 1'b0};
            for (int i = 0; i < ROWS*POSITIONS; i++) key_hist[i] = '0;
            for (int i = 0; i < ROWS; i++) key_rows[i] = '0;
            keys_down = 0;
            expected_reports.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_PRESS_SIXKEY: cfg.press_sixkey = i_cfg_wdata;
                    CFG_PRESS_NKEY:   cfg.press_nkey   = i_cfg_wdata;
                    CFG_RELEASE:      cfg.release_thr  = i_cfg_wdata;
                    CFG_NKEY_MODE:    cfg.nkey_mode    = i_cfg_wdata[0];
                    default: ;
                endcase
            end
            if (i_pop && !i_empty) begin
                if (expected_reports.size() == 0) begin
                    $display("%0t: unexpected result, expected none actual %0h/%0b/%0b/%0d",
                             $time, i_row_bits, i_key_down, i_changed, i_keys_down_total);
                    fails++;
                end else begin
                    want = expected_reports.pop_front();
                    check_field("row_bits", want.row_bits, i_row_bits);
                    check_field("key_down", 16'(want.key_down), 16'(i_key_down));
                    check_field("changed", 16'(want.changed), 16'(i_changed));
                    check_field("keys_down_total", 16'(want.total), 16'(i_keys_down_total));
                end
            end
            if (i_push && !i_full) begin
                expected_reports.push_back(debounce_sample(i_row_index, i_scan_position,
                                                           i_pressed));
            end
        end
        o_pending    <= expected_reports.size();
        o_fail_count <= fails;
    end

endmodule

FILE: bench/tb.sv
// Testbench top: drives key samples and threshold writes into the debouncer, gives the verdict.
module tb;
    import kmhd_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int STALL_CYCLES  = 80;
    localparam int SEGMENT_ITEMS = 185;
    localparam int SEGMENTS      = 6;
    localparam int HOT_KEYS      = 8;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 push;
    logic                 full;
    logic [2:0]           row_index;
    logic [3:0]           scan_position;
    logic                 pressed;
    logic                 empty;
    logic                 pop;
    logic [ROW_W-1:0]     row_bits;
    logic                 key_down;
    logic                 changed;
    logic [TOTAL_W-1:0]   keys_down_total;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_wdata;

    int fail_count;
    int pending;
    int send_idle_pct    = 0;
    int recv_idle_pct    = 0;
    int stall_asked      = 0;
    int stall_served     = 0;
    int stall_left       = 0;
    int items_sent       = 0;
    int settings_applied = 0;
    int cycle_count      = 0;

    logic [2:0] hot_row [HOT_KEYS];
    logic [3:0] hot_pos [HOT_KEYS];

    key_matrix_history_debouncer DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .push              (push),
        .full              (full),
        .i_row_index       (row_index),
        .i_scan_position   (scan_position),
        .i_pressed         (pressed),
        .empty             (empty),
        .pop               (pop),
        .o_row_bits        (row_bits),
        .o_key_down        (key_down),
        .o_changed         (changed),
        .o_keys_down_total (keys_down_total),
        .i_cfg_wr_en       (cfg_wr_en),
        .i_cfg_index       (cfg_index),
        .i_cfg_wdata       (cfg_wdata)
    );

    kmhd_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_push            (push),
        .i_full            (full),
        .i_row_index       (row_index),
        .i_scan_position   (scan_position),
        .i_pressed         (pressed),
        .i_empty           (empty),
        .i_pop             (pop),
        .i_row_bits        (row_bits),
        .i_key_down        (key_down),
        .i_changed         (changed),
        .i_keys_down_total (keys_down_total),
        .i_cfg_wr_en       (cfg_wr_en),
        .i_cfg_index       (cfg_index),
        .i_cfg_wdata       (cfg_wdata),
        .o_pending         (pending),
        .o_fail_count      (fail_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // result side: random pops, plus long hold-offs on request
    initial begin
        pop <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left == 0 && stall_served != stall_asked) begin
                stall_left = STALL_CYCLES;
                stall_served++;
            end
            if (stall_left > 0) begin
                stall_left--;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // push stays high after acceptance; drain() or an idle draw in the next call lowers it
    task automatic send_sample(input logic [2:0] r, input logic [3:0] p, input logic k);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push          <= 1'b1;
        row_index     <= r;
        scan_position <= p;
        pressed       <= k;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic drain();
        push <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic apply_setting(input logic [7:0] sixkey, input logic [7:0] nkey,
                                 input logic [7:0] rel, input logic mode);
        drain();
        repeat (4) @(posedge i_clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_PRESS_SIXKEY;
        cfg_wdata <= sixkey;
        @(posedge i_clk);
        cfg_index <= CFG_PRESS_NKEY;
        cfg_wdata <= nkey;
        @(posedge i_clk);
        cfg_index <= CFG_RELEASE;
        cfg_wdata <= rel;
        @(posedge i_clk);
        cfg_index <= CFG_NKEY_MODE;
        cfg_wdata <= {7'd0, mode};
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
        settings_applied++;
    endtask

    // one key held at a level, with occasional contact bounce
    task automatic key_burst();
        int         pick;
        int         len;
        logic [2:0] r;
        logic [3:0] p;
        logic       level;
        pick = $urandom_range(HOT_KEYS-1);
        if ($urandom_range(99) < 70) begin
            r = hot_row[pick];
            p = hot_pos[pick];
        end else begin
            r = 3'($urandom_range(7));
            p = 4'($urandom_range(15));
        end
        level = 1'($urandom_range(1));
        len = $urandom_range(1, 12);
        repeat (len) send_sample(r, p, ($urandom_range(99) < 10) ? !level : level);
    endtask

    task automatic run_segment(input int seg);
        int target;
        bit paused;
        paused = 1'b0;
        case (seg)
            0: apply_setting(8'd224, 8'd192, 8'd15, 1'b0);
            1: apply_setting(8'd224, 8'd192, 8'd15, 1'b1);
            2: apply_setting(8'd255, 8'd255, 8'd0, 1'b0);
            3: apply_setting(8'd0, 8'd0, 8'd255, 1'b1);
            default: apply_setting(8'($urandom_range(128, 255)), 8'($urandom_range(128, 255)),
                                   8'($urandom_range(0, 127)), 1'($urandom_range(1)));
        endcase
        send_idle_pct = (seg < 2) ? 34 : (seg < 4) ? 49 : 0;
        recv_idle_pct = (seg < 2) ? 49 : (seg < 4) ? 34 : 0;
        if (seg == 1 || seg == 5) stall_asked++;
        target = items_sent + SEGMENT_ITEMS;
        while (items_sent < target) begin
            if (seg == 3 && !paused && items_sent >= target - SEGMENT_ITEMS/2) begin
                drain();
                paused = 1'b1;
            end
            if ($urandom_range(99) < 80) begin
                key_burst();
            end else begin
                send_sample(3'($urandom_range(7)), 4'($urandom_range(15)),
                            1'($urandom_range(1)));
            end
        end
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        push          <= 1'b0;
        row_index     <= '0;
        scan_position <= '0;
        pressed       <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_index     <= CFG_PRESS_SIXKEY;
        cfg_wdata     <= '0;
        for (int i = 0; i < HOT_KEYS; i++) begin
            hot_row[i] = 3'($urandom_range(7));
            hot_pos[i] = 4'($urandom_range(15));
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_pct = 34;
        recv_idle_pct = 49;

        apply_setting(8'd224, 8'd192, 8'd15, 1'b0);
        // hold closed past saturation (no change at all ones), then open down to zero
        repeat (8) send_sample(3'd0, 4'd0, 1'b1);
        repeat (8) send_sample(3'd0, 4'd0, 1'b0);
        repeat (3) send_sample(3'd7, 4'd15, 1'b1);
        // press threshold below release threshold: press wins
        apply_setting(8'd8, 8'd192, 8'd200, 1'b0);
        send_sample(3'd3, 4'd5, 1'b1);
        send_sample(3'd3, 4'd5, 1'b0);
        apply_setting(8'd224, 8'd128, 8'd15, 1'b1);
        send_sample(3'd5, 4'd9, 1'b1);
        send_sample(3'd7, 4'd14, 1'b0);

        for (int seg = 0; seg < SEGMENTS; seg++) run_segment(seg);

        drain();
        repeat (10) @(posedge i_clk);
        $display("summary: %0d key samples over %0d threshold settings in %0d cycles,",
                 items_sent, settings_applied, cycle_count);
        $display("summary: bounce bursts, both idle mixes, result hold-offs and a full drain");
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

FILE: files.f
hdl/kmhd_pkg.sv
hdl/kmhd_queue.sv
hdl/kmhd_front.sv
hdl/kmhd_back.sv
hdl/key_matrix_history_debouncer.sv
bench/kmhd_checker.sv
bench/tb.sv
